// ===== hw/rtl/tspa_pkg.sv =====
// Shared constants and helpers for the triangle side, perimeter and area block.
// No dependencies.
package tspa_pkg;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int MAG_BITS   = COORD_BITS;
	localparam int SQ_BITS    = 2 * MAG_BITS + 1;
	localparam int RAD_BITS   = SQ_BITS + 2 * FRAC_BITS;
	localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
	localparam int RAD_PAD_BITS = 2 * ROOT_BITS;
	localparam int SIDE_BITS  = 25;
	localparam int PERIM_BITS = 27;
	localparam int AREA_BITS  = 33;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int CROSS_BITS = PROD_BITS + 1;
	localparam int SQRT_STAGES = ROOT_BITS;
	localparam int IN_BYTES_BITS  = 96;
	localparam int OUT_BYTES_BITS = 136;
endpackage

// ===== hw/rtl/tspa_sqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
// Depends on tspa_pkg.
module tspa_sqrt
	import tspa_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [SQ_BITS-1:0]   sq,
	output logic [ROOT_BITS-1:0] root
);
	logic [RAD_PAD_BITS-1:0] rad_q [SQRT_STAGES+1];
	logic [ROOT_BITS+1:0]    rem_q [SQRT_STAGES+1];
	logic [ROOT_BITS-1:0]    res_q [SQRT_STAGES+1];

	always_comb begin
		rad_q[0] = {{(RAD_PAD_BITS-RAD_BITS){1'b0}}, sq, {(2*FRAC_BITS){1'b0}}};
		rem_q[0] = '0;
		res_q[0] = '0;
	end

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_st
		logic [ROOT_BITS+1:0]    r_shift;
		logic [ROOT_BITS+1:0]    trial;
		logic [RAD_PAD_BITS-1:0] rad_pad;
		always_comb begin
			rad_pad = rad_q[i];
			r_shift = {rem_q[i][ROOT_BITS-1:0], rad_pad[RAD_PAD_BITS-1 -: 2]};
			trial   = {res_q[i], 2'b01};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[i+1] <= rad_q[i] << 2;
				if (r_shift >= trial) begin
					rem_q[i+1] <= r_shift - trial;
					res_q[i+1] <= {res_q[i][ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= r_shift;
					res_q[i+1] <= {res_q[i][ROOT_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign root = res_q[SQRT_STAGES];
endmodule

// ===== hw/rtl/tspa_delay.sv =====
// Enable-gated delay line matching the square root depth.
// Depends on tspa_pkg.
module tspa_delay
	import tspa_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [AREA_BITS:0]    din,
	output logic [AREA_BITS:0]    dout
);
	logic [AREA_BITS:0] tap_q [SQRT_STAGES];
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < SQRT_STAGES; i++) tap_q[i] <= tap_q[i-1];
		end
	end
	assign dout = tap_q[SQRT_STAGES-1];
endmodule

// ===== hw/rtl/triangle_side_perimeter_area.sv =====
// Top level of the triangle side, perimeter and area pipeline.
// Depends on tspa_pkg, tspa_sqrt and tspa_delay.
//
// Usage: s_axis carries one triangle per item, m_axis one result per item.
// Stage 1 forms coordinate differences, stage 2 squares and products,
// stage 3 squared lengths and the cross product, then ROOT_BITS (25) square
// root stages give one bit each, then one stage adds the perimeter.
// Throughput: one item per cycle while m_axis is not stalled, set by the bit-per-stage root pipeline.
// The whole pipeline advances when m_axis_tready is high or the output
// register is empty; s_axis_tready follows that enable, so a stall holds
// every stage and loses nothing. Reset clears all valid bits; data
// registers are not reset.
module triangle_side_perimeter_area
	import tspa_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_BYTES_BITS-1:0]  s_axis_tdata,  // ax, ay, bx, by_coord, cx, cy
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_BYTES_BITS-1:0] m_axis_tdata   // valid_res, side_ab, side_bc, side_ac, perimeter_len, area_doubled
);
	localparam int DEPTH = 3 + SQRT_STAGES + 1;
	logic [DEPTH-1:0] vld_q;
	logic en;
	assign en = m_axis_tready || !vld_q[DEPTH-1];
	assign s_axis_tready = en;

	logic signed [COORD_BITS-1:0] ax, ay, bx, by_coord, cx, cy;
	assign ax = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
	assign ay = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
	assign bx = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
	assign by_coord = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
	assign cx = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
	assign cy = s_axis_tdata[5*COORD_BITS +: COORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
		end
	end

	logic signed [DIFF_BITS-1:0] dabx_s1, daby_s1, dbcx_s1, dbcy_s1, dacx_s1, dacy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dabx_s1 <= DIFF_BITS'(ax) - DIFF_BITS'(bx);
			daby_s1 <= DIFF_BITS'(ay) - DIFF_BITS'(by_coord);
			dbcx_s1 <= DIFF_BITS'(bx) - DIFF_BITS'(cx);
			dbcy_s1 <= DIFF_BITS'(by_coord) - DIFF_BITS'(cy);
			dacx_s1 <= DIFF_BITS'(ax) - DIFF_BITS'(cx);
			dacy_s1 <= DIFF_BITS'(ay) - DIFF_BITS'(cy);
		end
	end

	logic [PROD_BITS-1:0] sabx_s2, saby_s2, sbcx_s2, sbcy_s2, sacx_s2, sacy_s2;
	logic signed [PROD_BITS-1:0] p1_s2, p2_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sabx_s2 <= PROD_BITS'(dabx_s1 * dabx_s1);
			saby_s2 <= PROD_BITS'(daby_s1 * daby_s1);
			sbcx_s2 <= PROD_BITS'(dbcx_s1 * dbcx_s1);
			sbcy_s2 <= PROD_BITS'(dbcy_s1 * dbcy_s1);
			sacx_s2 <= PROD_BITS'(dacx_s1 * dacx_s1);
			sacy_s2 <= PROD_BITS'(dacy_s1 * dacy_s1);
			// (A-B)x(C-B) = dab.x * (-dbc.y) - (-dbc.x) * dab.y
			p1_s2 <= dbcx_s1 * daby_s1;
			p2_s2 <= dabx_s1 * dbcy_s1;
		end
	end

	logic [SQ_BITS-1:0] qab_s3, qbc_s3, qac_s3;
	logic [AREA_BITS:0] area_s3;
	logic signed [CROSS_BITS-1:0] xprod;
	assign xprod = CROSS_BITS'(p1_s2) - CROSS_BITS'(p2_s2);
	always_ff @(posedge clk) begin
		if (en) begin
			qab_s3 <= SQ_BITS'(sabx_s2) + SQ_BITS'(saby_s2);
			qbc_s3 <= SQ_BITS'(sbcx_s2) + SQ_BITS'(sbcy_s2);
			qac_s3 <= SQ_BITS'(sacx_s2) + SQ_BITS'(sacy_s2);
			area_s3 <= {xprod != 0,
				AREA_BITS'(xprod[CROSS_BITS-1] ? -xprod : xprod)};
		end
	end

	logic [ROOT_BITS-1:0] rab, rbc, rac;
	logic [AREA_BITS:0] area_d;
	tspa_sqrt u_sab (.clk, .en, .sq(qab_s3), .root(rab));
	tspa_sqrt u_sbc (.clk, .en, .sq(qbc_s3), .root(rbc));
	tspa_sqrt u_sac (.clk, .en, .sq(qac_s3), .root(rac));
	tspa_delay u_dly (.clk, .en, .din(area_s3), .dout(area_d));

	logic [SIDE_BITS-1:0] ab_q, bc_q, ac_q;
	logic [PERIM_BITS-1:0] per_q;
	logic [AREA_BITS:0] area_q;
	always_ff @(posedge clk) begin
		if (en) begin
			ab_q <= SIDE_BITS'(rab);
			bc_q <= SIDE_BITS'(rbc);
			ac_q <= SIDE_BITS'(rac);
			per_q <= PERIM_BITS'(rab) + PERIM_BITS'(rbc) + PERIM_BITS'(rac);
			area_q <= area_d;
		end
	end

	assign m_axis_tvalid = vld_q[DEPTH-1];
	assign m_axis_tdata = {area_q[AREA_BITS-1:0], per_q, ac_q, bc_q, ab_q,
		area_q[AREA_BITS]};
endmodule
